>>> src/ttb_pkg.sv
package ttb_pkg;

    // Field width is fixed by the payload structs.
    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = DATA_WIDTH - 2;
    localparam int DELTA_SHIFT = (DATA_WIDTH > 16) ? DATA_WIDTH - 16 : 0;
    localparam int DELTA_W     = ((DATA_WIDTH < 16) ? DATA_WIDTH : 16) + 1;
    localparam int MUL_W       = (DATA_WIDTH + 2 > 22) ? DATA_WIDTH + 2 : 22;
    localparam int ACC_W       = 2 * MUL_W + 2;
    localparam int VEC_W       = (2 * DELTA_W + 2 > DATA_WIDTH + 3) ?
                                 2 * DELTA_W + 2 : DATA_WIDTH + 3;
    localparam int SQ_W        = 44;
    localparam int LEN_W       = 22;
    localparam int SQRT_STEPS  = 22;
    localparam int NUM_W       = FRAC_BITS + 22;
    localparam int DIV_STEPS   = NUM_W;
    localparam int CNT_W       = $clog2((NUM_W > SQRT_STEPS) ? NUM_W : SQRT_STEPS);

    typedef logic signed [DATA_WIDTH-1:0] comp_t;

    typedef struct packed {
        comp_t pos_x;
        comp_t pos_y;
        comp_t pos_z;
        comp_t tex_u;
        comp_t tex_v;
        comp_t nor_x;
        comp_t nor_y;
        comp_t nor_z;
    } ttb_in_t;

    typedef struct packed {
        comp_t       tan_x;
        comp_t       tan_y;
        comp_t       tan_z;
        comp_t       bitan_x;
        comp_t       bitan_y;
        comp_t       bitan_z;
        logic [1:0]  corner;
        logic        degenerate;
        logic        last;
    } ttb_out_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_HOLD,
        OP_CAPTURE,
        OP_MAC,
        OP_DET_WR,
        OP_RAW_WR,
        OP_NORM,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_WR,
        OP_ZERO,
        OP_CORNER,
        OP_D_WR,
        OP_V_WR,
        OP_EMIT
    } ttb_op_t;

    typedef enum logic [3:0] {
        MS_DET0,
        MS_DET1,
        MS_T0,
        MS_T1,
        MS_B0,
        MS_B1,
        MS_SQ,
        MS_DOT,
        MS_ND
    } ttb_mul_t;

    typedef enum logic [1:0] {
        DST_T,
        DST_B,
        DST_TV,
        DST_BV
    } ttb_dst_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DET,
        S_DET_WR,
        S_RAW,
        S_RAW_WR,
        S_CHK,
        S_NORM,
        S_SQ,
        S_SQRT_INIT,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_DIV_WR,
        S_ZERO,
        S_CORNER,
        S_DOT,
        S_D_WR,
        S_ND,
        S_V_WR,
        S_EMIT
    } ttb_state_t;

    typedef struct packed {
        ttb_op_t    op;
        ttb_mul_t   mul;
        logic       sub;
        logic       first;
        logic [1:0] k;
        ttb_dst_t   dst;
        logic [1:0] corner;
    } ttb_cmd_t;

    typedef struct packed {
        logic in_range;
        logic vec_zero;
        logic tri_bad;
        logic out_busy;
    } ttb_sts_t;

endpackage

>>> src/ttb_ctrl.sv
module ttb_ctrl
    import ttb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ttb_sts_t sts,
    output ttb_cmd_t cmd
);

    ttb_state_t       state_reg,  state_next;
    logic [1:0]       vcnt_reg,   vcnt_next;
    logic [1:0]       k_reg,      k_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    ttb_dst_t         phase_reg,  phase_next;
    logic [1:0]       corner_reg, corner_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            vcnt_reg   <= '0;
            k_reg      <= '0;
            cnt_reg    <= '0;
            phase_reg  <= DST_T;
            corner_reg <= '0;
        end else begin
            state_reg  <= state_next;
            vcnt_reg   <= vcnt_next;
            k_reg      <= k_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
            corner_reg <= corner_next;
        end
    end

    // next state
    always_comb begin
        state_next  = state_reg;
        vcnt_next   = vcnt_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        corner_next = corner_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (vcnt_reg < 2'd2) begin
                        vcnt_next = vcnt_reg + 2'd1;
                    end else begin
                        vcnt_next  = '0;
                        cnt_next   = '0;
                        state_next = S_DET;
                    end
                end
            end
            S_DET: begin
                if (cnt_reg == '0) begin
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    state_next = S_DET_WR;
                end
            end
            S_DET_WR: begin
                k_next     = '0;
                cnt_next   = '0;
                phase_next = DST_T;
                state_next = S_RAW;
            end
            S_RAW: begin
                if (cnt_reg == '0) begin
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    state_next = S_RAW_WR;
                end
            end
            S_RAW_WR: begin
                cnt_next = '0;
                if (k_reg == 2'd2) begin
                    state_next = S_CHK;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_RAW;
                end
            end
            S_CHK: begin
                state_next = sts.vec_zero ? S_ZERO : S_NORM;
            end
            S_NORM: begin
                if (sts.in_range) begin
                    k_next     = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ: begin
                if (k_reg == 2'd2) begin
                    state_next = S_SQRT_INIT;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_SQRT_INIT: begin
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    k_next     = '0;
                    state_next = S_DIV_INIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV_INIT: begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_DIV_WR;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV_WR, S_ZERO: begin
                if (state_reg == S_DIV_WR && k_reg != 2'd2) begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_DIV_INIT;
                end else begin
                    // unit vector finished: move on by phase
                    k_next   = '0;
                    cnt_next = '0;
                    case (phase_reg)
                        DST_T: begin
                            phase_next = DST_B;
                            state_next = S_RAW;
                        end
                        DST_B: begin
                            corner_next = '0;
                            state_next  = S_CORNER;
                        end
                        DST_TV: begin
                            phase_next = DST_BV;
                            state_next = S_DOT;
                        end
                        default: begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_CORNER: begin
                k_next = '0;
                if (sts.tri_bad) begin
                    state_next = S_EMIT;
                end else begin
                    phase_next = DST_TV;
                    state_next = S_DOT;
                end
            end
            S_DOT: begin
                if (k_reg == 2'd2) begin
                    state_next = S_D_WR;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_D_WR: begin
                k_next     = '0;
                state_next = S_ND;
            end
            S_ND: begin
                state_next = S_V_WR;
            end
            S_V_WR: begin
                if (k_reg == 2'd2) begin
                    state_next = S_CHK;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_ND;
                end
            end
            S_EMIT: begin
                if (!sts.out_busy) begin
                    if (corner_reg == 2'd2) begin
                        state_next = S_IDLE;
                    end else begin
                        corner_next = corner_reg + 2'd1;
                        state_next  = S_CORNER;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready    = 1'b0;
        cmd.op     = OP_NONE;
        cmd.mul    = MS_SQ;
        cmd.sub    = 1'b0;
        cmd.first  = 1'b0;
        cmd.k      = k_reg;
        cmd.dst    = phase_reg;
        cmd.corner = corner_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                cmd.k   = vcnt_reg;
                if (s_valid) begin
                    cmd.op = (vcnt_reg < 2'd2) ? OP_HOLD : OP_CAPTURE;
                end
            end
            S_DET: begin
                cmd.op    = OP_MAC;
                cmd.mul   = (cnt_reg == '0) ? MS_DET0 : MS_DET1;
                cmd.first = (cnt_reg == '0);
                cmd.sub   = (cnt_reg != '0);
            end
            S_DET_WR:    cmd.op = OP_DET_WR;
            S_RAW: begin
                cmd.op    = OP_MAC;
                cmd.first = (cnt_reg == '0);
                cmd.sub   = (cnt_reg != '0);
                if (phase_reg == DST_T) begin
                    cmd.mul = (cnt_reg == '0) ? MS_T0 : MS_T1;
                end else begin
                    cmd.mul = (cnt_reg == '0) ? MS_B0 : MS_B1;
                end
            end
            S_RAW_WR:    cmd.op = OP_RAW_WR;
            S_NORM:      cmd.op = OP_NORM;
            S_SQ: begin
                cmd.op    = OP_MAC;
                cmd.mul   = MS_SQ;
                cmd.first = (k_reg == 2'd0);
            end
            S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
            S_SQRT:      cmd.op = OP_SQRT_STEP;
            S_DIV_INIT:  cmd.op = OP_DIV_INIT;
            S_DIV:       cmd.op = OP_DIV_STEP;
            S_DIV_WR:    cmd.op = OP_DIV_WR;
            S_ZERO:      cmd.op = OP_ZERO;
            S_CORNER:    cmd.op = OP_CORNER;
            S_DOT: begin
                cmd.op    = OP_MAC;
                cmd.mul   = MS_DOT;
                cmd.first = (k_reg == 2'd0);
            end
            S_D_WR:      cmd.op = OP_D_WR;
            S_ND: begin
                cmd.op    = OP_MAC;
                cmd.mul   = MS_ND;
                cmd.first = 1'b1;
            end
            S_V_WR:      cmd.op = OP_V_WR;
            S_EMIT: begin
                if (!sts.out_busy) begin
                    cmd.op = OP_EMIT;
                end
            end
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> src/ttb_dp.sv
module ttb_dp
    import ttb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  ttb_in_t  s_data,
    input  ttb_cmd_t cmd,
    output ttb_sts_t sts,
    output logic     m_valid,
    input  logic     m_ready,
    output ttb_out_t m_data
);

    localparam comp_t C_ONE = comp_t'(1) <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic [VEC_W-1:0] NORM_HI = VEC_W'(1) << 20;
    localparam logic [VEC_W-1:0] NORM_LO = VEC_W'(1) << 19;
    localparam logic [NUM_W-1:0] Q_ONE = NUM_W'(1) << FRAC_BITS;
    localparam logic [SQ_W-1:0] SQ_BIT0 = SQ_W'(1) << (2 * (SQRT_STEPS - 1));

    typedef logic signed [DELTA_W-1:0] dlt_t;
    typedef logic signed [VEC_W-1:0]   vec_t;
    typedef logic signed [MUL_W-1:0]   mop_t;

    function automatic comp_t sat_nor(input comp_t n);
        comp_t r;
        r = n;
        if (n > C_ONE) r = C_ONE;
        if (n < -C_ONE) r = -C_ONE;
        return r;
    endfunction

    function automatic dlt_t delta(input comp_t a, input comp_t b);
        logic signed [DATA_WIDTH:0] diff;
        diff = (DATA_WIDTH+1)'(a) - (DATA_WIDTH+1)'(b);
        return DELTA_W'(diff >>> DELTA_SHIFT);
    endfunction

    comp_t held_pos_reg [0:1][0:2];
    comp_t held_tex_reg [0:1][0:1];
    comp_t held_nor_reg [0:1][0:2];
    comp_t nor2_reg     [0:2];
    dlt_t  dp1_reg [0:2];
    dlt_t  dp2_reg [0:2];
    dlt_t  du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic  det_neg_reg, tri_bad_reg, corner_bad_reg;
    vec_t  vec_reg [0:2];
    logic  lost_reg [0:2];
    logic [SQ_W-1:0]  sqx_reg, sqr_reg, sqb_reg;
    logic [NUM_W-1:0] num_reg, quo_reg;
    logic [LEN_W:0]   rem_reg;
    logic  dsign_reg;
    comp_t tq_reg [0:2];
    comp_t bq_reg [0:2];
    comp_t tv_reg [0:2];
    comp_t bv_reg [0:2];
    mop_t  d_reg;
    ttb_out_t out_reg;
    logic  m_valid_reg;

    comp_t in_pos [0:2];
    comp_t in_tex [0:1];
    comp_t in_nor [0:2];
    comp_t nsel, usel;
    mop_t  op_a, op_b;
    logic signed [2*MUL_W-1:0] prod;
    logic signed [ACC_W-1:0]   acc_add, acc_rnd;
    logic [VEC_W-1:0] vabs [0:2];
    logic [2:0] over_hi;
    logic big, tiny;
    logic [LEN_W-1:0] len;
    logic [SQ_W-1:0]  sq_rb;
    logic [LEN_W+1:0] div_shift, div_d;
    logic [NUM_W-1:0] q_clamp;
    comp_t q_res;

    assign in_pos[0] = s_data.pos_x;
    assign in_pos[1] = s_data.pos_y;
    assign in_pos[2] = s_data.pos_z;
    assign in_tex[0] = s_data.tex_u;
    assign in_tex[1] = s_data.tex_v;
    assign in_nor[0] = s_data.nor_x;
    assign in_nor[1] = s_data.nor_y;
    assign in_nor[2] = s_data.nor_z;

    always_comb begin
        case (cmd.corner)
            2'd0:    nsel = held_nor_reg[0][cmd.k];
            2'd1:    nsel = held_nor_reg[1][cmd.k];
            default: nsel = nor2_reg[cmd.k];
        endcase
        usel = (cmd.dst == DST_BV) ? bq_reg[cmd.k] : tq_reg[cmd.k];
    end

    // shared multiplier operand select
    always_comb begin
        case (cmd.mul)
            MS_DET0: begin op_a = MUL_W'(du1_reg);     op_b = MUL_W'(dv2_reg); end
            MS_DET1: begin op_a = MUL_W'(dv1_reg);     op_b = MUL_W'(du2_reg); end
            MS_T0:   begin op_a = MUL_W'(dp1_reg[cmd.k]); op_b = MUL_W'(dv2_reg); end
            MS_T1:   begin op_a = MUL_W'(dp2_reg[cmd.k]); op_b = MUL_W'(dv1_reg); end
            MS_B0:   begin op_a = MUL_W'(dp2_reg[cmd.k]); op_b = MUL_W'(du1_reg); end
            MS_B1:   begin op_a = MUL_W'(dp1_reg[cmd.k]); op_b = MUL_W'(du2_reg); end
            MS_SQ:   begin op_a = MUL_W'(vec_reg[cmd.k]); op_b = MUL_W'(vec_reg[cmd.k]); end
            MS_DOT:  begin op_a = MUL_W'(nsel);        op_b = MUL_W'(usel); end
            MS_ND:   begin op_a = MUL_W'(nsel);        op_b = d_reg; end
            default: begin op_a = '0;                  op_b = '0; end
        endcase
    end

    assign prod    = op_a * op_b;
    assign acc_add = (cmd.first ? '0 : acc_reg) +
                     (cmd.sub ? -ACC_W'(prod) : ACC_W'(prod));
    assign acc_rnd = (acc_reg + ACC_HALF) >>> FRAC_BITS;

    // a negative component floored onto -2^20 is only still too big when
    // no ones were shifted out of it
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vabs[i] = vec_reg[i][VEC_W-1] ? VEC_W'(-vec_reg[i]) : VEC_W'(vec_reg[i]);
            over_hi[i] = (vabs[i] > NORM_HI) ||
                         ((vabs[i] == NORM_HI) && !(vec_reg[i][VEC_W-1] && lost_reg[i]));
        end
        big  = |over_hi;
        tiny = (vabs[0] < NORM_LO) && (vabs[1] < NORM_LO) && (vabs[2] < NORM_LO);
    end

    assign len       = sqr_reg[LEN_W-1:0];
    assign sq_rb     = sqr_reg + sqb_reg;
    assign div_shift = {rem_reg, num_reg[NUM_W-1]};
    assign div_d     = {1'b0, len, 1'b0};
    assign q_clamp   = (quo_reg > Q_ONE) ? Q_ONE : quo_reg;
    assign q_res     = dsign_reg ? -comp_t'(q_clamp) : comp_t'(q_clamp);

    assign sts.in_range = !big && !tiny;
    assign sts.vec_zero = (vec_reg[0] == '0) && (vec_reg[1] == '0) && (vec_reg[2] == '0);
    assign sts.tri_bad  = tri_bad_reg;
    assign sts.out_busy = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_EMIT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_HOLD: begin
                for (int i = 0; i < 3; i++) begin
                    held_pos_reg[cmd.k[0]][i] <= in_pos[i];
                    held_nor_reg[cmd.k[0]][i] <= sat_nor(in_nor[i]);
                end
                held_tex_reg[cmd.k[0]][0] <= in_tex[0];
                held_tex_reg[cmd.k[0]][1] <= in_tex[1];
            end
            OP_CAPTURE: begin
                for (int i = 0; i < 3; i++) begin
                    nor2_reg[i] <= sat_nor(in_nor[i]);
                    dp1_reg[i]  <= delta(held_pos_reg[1][i], held_pos_reg[0][i]);
                    dp2_reg[i]  <= delta(in_pos[i], held_pos_reg[0][i]);
                end
                du1_reg <= delta(held_tex_reg[1][0], held_tex_reg[0][0]);
                dv1_reg <= delta(held_tex_reg[1][1], held_tex_reg[0][1]);
                du2_reg <= delta(in_tex[0], held_tex_reg[0][0]);
                dv2_reg <= delta(in_tex[1], held_tex_reg[0][1]);
            end
            OP_MAC: begin
                acc_reg <= acc_add;
            end
            OP_DET_WR: begin
                det_neg_reg <= acc_reg[ACC_W-1];
                tri_bad_reg <= (acc_reg == '0);
            end
            OP_RAW_WR: begin
                vec_reg[cmd.k]  <= det_neg_reg ? -VEC_W'(acc_reg) : VEC_W'(acc_reg);
                lost_reg[cmd.k] <= 1'b0;
            end
            OP_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    if (big) begin
                        vec_reg[i] <= vec_reg[i] >>> 1;
                        if (vec_reg[i][0]) lost_reg[i] <= 1'b1;
                    end else if (tiny) begin
                        vec_reg[i] <= vec_reg[i] <<< 1;
                    end
                end
            end
            OP_SQRT_INIT: begin
                sqx_reg <= acc_reg[SQ_W-1:0];
                sqr_reg <= '0;
                sqb_reg <= SQ_BIT0;
            end
            OP_SQRT_STEP: begin
                if (sqx_reg >= sq_rb) begin
                    sqx_reg <= sqx_reg - sq_rb;
                    sqr_reg <= (sqr_reg >> 1) + sqb_reg;
                end else begin
                    sqr_reg <= sqr_reg >> 1;
                end
                sqb_reg <= sqb_reg >> 2;
            end
            OP_DIV_INIT: begin
                num_reg   <= (NUM_W'(vabs[cmd.k][20:0]) << (FRAC_BITS + 1)) + NUM_W'(len);
                rem_reg   <= '0;
                quo_reg   <= '0;
                dsign_reg <= vec_reg[cmd.k][VEC_W-1];
            end
            OP_DIV_STEP: begin
                num_reg <= num_reg << 1;
                if (div_shift >= div_d) begin
                    rem_reg <= (LEN_W+1)'(div_shift - div_d);
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= div_shift[LEN_W:0];
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                end
            end
            OP_DIV_WR: begin
                case (cmd.dst)
                    DST_T:   tq_reg[cmd.k] <= q_res;
                    DST_B:   bq_reg[cmd.k] <= q_res;
                    DST_TV:  tv_reg[cmd.k] <= q_res;
                    default: bv_reg[cmd.k] <= q_res;
                endcase
            end
            OP_ZERO: begin
                for (int i = 0; i < 3; i++) begin
                    case (cmd.dst)
                        DST_T:   tq_reg[i] <= '0;
                        DST_B:   bq_reg[i] <= '0;
                        DST_TV:  tv_reg[i] <= '0;
                        default: bv_reg[i] <= '0;
                    endcase
                end
                if (cmd.dst == DST_T || cmd.dst == DST_B) begin
                    tri_bad_reg <= 1'b1;
                end else begin
                    corner_bad_reg <= 1'b1;
                end
            end
            OP_CORNER: begin
                for (int i = 0; i < 3; i++) begin
                    tv_reg[i] <= '0;
                    bv_reg[i] <= '0;
                end
                corner_bad_reg <= tri_bad_reg;
            end
            OP_D_WR: begin
                d_reg <= MUL_W'(acc_rnd);
            end
            OP_V_WR: begin
                vec_reg[cmd.k]  <= VEC_W'(usel) - VEC_W'(acc_rnd);
                lost_reg[cmd.k] <= 1'b0;
            end
            OP_EMIT: begin
                out_reg.tan_x      <= tv_reg[0];
                out_reg.tan_y      <= tv_reg[1];
                out_reg.tan_z      <= tv_reg[2];
                out_reg.bitan_x    <= bv_reg[0];
                out_reg.bitan_y    <= bv_reg[1];
                out_reg.bitan_z    <= bv_reg[2];
                out_reg.corner     <= cmd.corner;
                out_reg.degenerate <= corner_bad_reg;
                out_reg.last       <= (cmd.corner == 2'd2);
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> src/triangle_tangent_basis.sv
// Tangent/bitangent generator for one triangle at a time.
// Input channel (s_valid/s_ready/s_data): one vertex per request, three per
// triangle in order. Vertices 0 and 1 are held without stalling the input.
// Vertex 2 starts the computation; s_ready stays low until the three results
// of that triangle have all been handed to the output register.
// Output channel (m_valid/m_ready/m_data): three results per triangle, corner
// 0, 1, 2, with last set on corner 2.
// The work is eight normalizations through one iterative unit: a shift
// loop, three multiply-accumulates on one shared multiplier, a square root
// and three restoring divides. A degenerate triangle skips the six
// per-corner normalizations.
// A stalled receiver holds the current result in the output register; the
// next result waits behind it.
// Reset (aresetn low, synchronous) clears the vertex count and the
// controller, and drops m_valid. Held vertices are not cleared.
module triangle_tangent_basis
    import ttb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ttb_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ttb_out_t m_data
);

    ttb_cmd_t cmd;
    ttb_sts_t sts;

    ttb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ttb_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> src/ttb_checker.sv
module ttb_checker
    import ttb_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input ttb_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input ttb_out_t m_data
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input request dropped or changed while stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (m_data.corner == 2'd2)))
        else $error("last flag does not match corner");

    a_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.corner != 2'd3))
        else $error("corner index out of range");

endmodule

bind triangle_tangent_basis ttb_checker u_ttb_checker (.*);

>>> tb/tb_triangle_tangent_basis.sv
`timescale 1ns / 1ps

import ttb_pkg::*;

class basis_scoreboard;
    ttb_out_t pending_basis[$];
    int       mismatches;

    // held vertices of the triangle being assembled
    longint   hp[2][3];
    longint   ht[2][2];
    longint   hn[2][3];
    int       vcount;

    function longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function longint isqrt(longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function bit unit_vec(input longint v[3], output longint o[3]);
        longint m, a, sq, len, c, one;
        longint t[3];
        int bw;
        one = 64'sd1 <<< FRAC_BITS;
        m = 0;
        sq = 0;
        for (int k = 0; k < 3; k++) begin
            a = v[k] < 0 ? -v[k] : v[k];
            if (a > m) m = a;
            o[k] = 0;
        end
        if (m == 0) return 0;
        bw = 0;
        while (bw < 63 && (m >>> bw) != 0) bw++;
        for (int k = 0; k < 3; k++) begin
            if (bw > 20) t[k] = fshr(v[k], bw - 20);
            else t[k] = v[k] <<< (20 - bw);
            sq += t[k] * t[k];
        end
        len = isqrt(sq);
        for (int k = 0; k < 3; k++) begin
            a = t[k] < 0 ? -t[k] : t[k];
            c = ((a <<< (FRAC_BITS + 1)) + len) / (2 * len);
            if (c > one) c = one;
            o[k] = t[k] < 0 ? -c : c;
        end
        return 1;
    endfunction

    function bit reject_normal(input longint n[3], input longint u[3], output longint o[3]);
        longint d, half;
        longint v[3];
        half = 64'sd1 <<< (FRAC_BITS - 1);
        d = 0;
        for (int k = 0; k < 3; k++) d += n[k] * u[k];
        d = fshr(d + half, FRAC_BITS);
        for (int k = 0; k < 3; k++) v[k] = u[k] - fshr(n[k] * d + half, FRAC_BITS);
        return unit_vec(v, o);
    endfunction

    function void note_vertex(ttb_in_t vin);
        longint p[3][3], tx[3][2], n[3][3];
        longint dp1[3], dp2[3], tr[3], br[3], tq[3], bq[3], tv[3], bv[3];
        longint du1, dv1, du2, dv2, det, one;
        bit ok, ga, gb;
        ttb_out_t r;
        one = 64'sd1 <<< FRAC_BITS;
        p[2][0] = longint'(vin.pos_x); p[2][1] = longint'(vin.pos_y);
        p[2][2] = longint'(vin.pos_z);
        tx[2][0] = longint'(vin.tex_u); tx[2][1] = longint'(vin.tex_v);
        n[2][0] = longint'(vin.nor_x); n[2][1] = longint'(vin.nor_y);
        n[2][2] = longint'(vin.nor_z);
        for (int k = 0; k < 3; k++) begin
            if (n[2][k] > one) n[2][k] = one;
            if (n[2][k] < -one) n[2][k] = -one;
        end
        if (vcount < 2) begin
            hp[vcount] = p[2];
            ht[vcount] = tx[2];
            hn[vcount] = n[2];
            vcount++;
            return;
        end
        vcount = 0;
        for (int c = 0; c < 2; c++) begin
            p[c] = hp[c];
            tx[c] = ht[c];
            n[c] = hn[c];
        end
        for (int k = 0; k < 3; k++) begin
            dp1[k] = fshr(p[1][k] - p[0][k], DELTA_SHIFT);
            dp2[k] = fshr(p[2][k] - p[0][k], DELTA_SHIFT);
        end
        du1 = fshr(tx[1][0] - tx[0][0], DELTA_SHIFT);
        dv1 = fshr(tx[1][1] - tx[0][1], DELTA_SHIFT);
        du2 = fshr(tx[2][0] - tx[0][0], DELTA_SHIFT);
        dv2 = fshr(tx[2][1] - tx[0][1], DELTA_SHIFT);
        det = du1 * dv2 - dv1 * du2;
        for (int k = 0; k < 3; k++) begin
            tr[k] = dp1[k] * dv2 - dp2[k] * dv1;
            br[k] = dp2[k] * du1 - dp1[k] * du2;
            if (det < 0) begin
                tr[k] = -tr[k];
                br[k] = -br[k];
            end
        end
        ok = det != 0;
        if (!unit_vec(tr, tq)) ok = 0;
        if (!unit_vec(br, bq)) ok = 0;
        for (int c = 0; c < 3; c++) begin
            tv = '{0, 0, 0};
            bv = '{0, 0, 0};
            r.degenerate = 1'b1;
            if (ok) begin
                ga = reject_normal(n[c], tq, tv);
                gb = reject_normal(n[c], bq, bv);
                r.degenerate = !(ga && gb);
            end
            r.tan_x = comp_t'(tv[0]); r.tan_y = comp_t'(tv[1]); r.tan_z = comp_t'(tv[2]);
            r.bitan_x = comp_t'(bv[0]); r.bitan_y = comp_t'(bv[1]);
            r.bitan_z = comp_t'(bv[2]);
            r.corner = 2'(c);
            r.last = (c == 2);
            pending_basis.insert(pending_basis.size(), r);
        end
    endfunction

    function void check_basis(ttb_out_t got);
        ttb_out_t want;
        if (pending_basis.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending_basis.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h got %h", want, got);
        end
    endfunction
endclass

module tb_triangle_tangent_basis;
    logic     aclk = 0;
    logic     aresetn = 0;
    logic     s_valid = 0;
    logic     s_ready;
    ttb_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 0;
    ttb_out_t m_data;

    basis_scoreboard sb = new();
    bit       stim_done = 0;
    int       idle_mode = 1;

    triangle_tangent_basis uut (.*);

    always #1 aclk = ~aclk;

    function int gap_len();
        if (idle_mode == 0) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // valid stays up between back-to-back requests; it only drops for a gap
    task send_vertex(ttb_in_t v);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        do @(posedge aclk); while (!s_ready);
        sb.note_vertex(v);
    endtask

    function logic signed [15:0] rand_norm();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sd16384;
        if (r == 1) return -16'sd16384;
        if (r == 2) return 16'($urandom);    // may be out of range, then saturated
        return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endfunction

    function ttb_in_t rand_vertex(int spread);
        ttb_in_t v;
        v = '0;
        v.pos_x = $signed(16'($urandom)) >>> spread;
        v.pos_y = $signed(16'($urandom)) >>> spread;
        v.pos_z = $signed(16'($urandom)) >>> spread;
        v.tex_u = $signed(16'($urandom)) >>> spread;
        v.tex_v = $signed(16'($urandom)) >>> spread;
        v.nor_x = rand_norm();
        v.nor_y = rand_norm();
        v.nor_z = rand_norm();
        return v;
    endfunction

    function ttb_in_t mk(int px, int py, int pz, int u, int vv, int nx, int ny, int nz);
        ttb_in_t v;
        v.pos_x = comp_t'(px); v.pos_y = comp_t'(py); v.pos_z = comp_t'(pz);
        v.tex_u = comp_t'(u); v.tex_v = comp_t'(vv);
        v.nor_x = comp_t'(nx); v.nor_y = comp_t'(ny); v.nor_z = comp_t'(nz);
        return v;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_basis(m_data);
            if (idle_mode == 0) m_ready <= 1'b1;
            else m_ready <= (gap_len() == 0);
        end
    end

    initial begin
        ttb_in_t v;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // plain triangle in the xy plane, normal +z
        send_vertex(mk(0, 0, 0, 0, 0, 0, 0, 16384));
        send_vertex(mk(256, 0, 0, 4096, 0, 0, 0, 16384));
        send_vertex(mk(0, 256, 0, 0, 4096, 0, 0, 16384));
        // zero UV determinant
        send_vertex(mk(0, 0, 0, 100, 100, 0, 16384, 0));
        send_vertex(mk(256, 0, 0, 100, 100, 0, 16384, 0));
        send_vertex(mk(0, 256, 0, 100, 100, 0, 16384, 0));
        // extreme fields, saturated normals
        send_vertex(mk(-32768, 32767, -32768, -32768, 32767, -32768, 32767, -32768));
        send_vertex(mk(32767, -32768, 32767, 32767, -32768, 32767, -32768, 32767));
        send_vertex(mk(-32768, -32768, 32767, 32767, 32767, -16384, 16384, 0));
        // negative determinant; normal parallel to tangent kills the corner
        send_vertex(mk(0, 0, 0, 0, 0, 16384, 0, 0));
        send_vertex(mk(256, 0, 0, -4096, 0, 16384, 0, 0));
        send_vertex(mk(0, 256, 0, 0, 4096, 0, 0, 0));
        // collinear positions give zero tangent
        send_vertex(mk(0, 0, 0, 0, 0, 0, 0, 16384));
        send_vertex(mk(0, 0, 0, 4096, 0, 0, 0, 16384));
        send_vertex(mk(0, 0, 0, 0, 4096, 0, 0, 16384));
        for (int i = 0; i < 300; i++) begin
            if (i % 60 == 0) idle_mode = (i / 60) % 3 != 1;
            v = rand_vertex((i % 7 == 0) ? 0 : $urandom_range(0, 12));
            send_vertex(v);
        end
        // finish the open triangle
        while (sb.vcount != 0) send_vertex(rand_vertex(4));
        s_valid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (sb.pending_basis.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
